// ===== sv/swhc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swhc_pkg: shared types and constants of the sliding window hit counter
// Field widths, the default window length and the controller-to-datapath
// command and status bundles.
// ----------------------------------------------------------------------------
package swhc_pkg;

	localparam int TS_W           = 31;  // timestamp width
	localparam int CNT_W          = 32;  // bucket count and sum width
	localparam int MOD_STEPS      = 2;   // cycles of the slot computation
	localparam int STEP_W         = 1;   // holds MOD_STEPS - 1
	localparam int WINDOW_DEFAULT = 300;

	// commands from the controller, decoded from its state
	typedef struct packed {
		logic clr_wr;    // write a zero entry at idx
		logic mod_init;  // latch item, start slot computation
		logic mod_step;  // one step of timestamp mod window
		logic slot_rd;   // read the addressed bucket
		logic slot_wr;   // write the updated bucket
		logic sweep_rd;  // read bucket idx for the sum
		logic out_load;  // move sum into the output register
	} cmd_t;

	typedef struct packed {
		logic hit;       // current item records a hit
	} sts_t;

endpackage

// ===== sv/swhc_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swhc_ctrl: sequencer of the sliding window hit counter
// Clearing pass, slot computation, bucket update, window sweep and output
// handshake.
// ----------------------------------------------------------------------------
module swhc_ctrl #(
	parameter int WINDOW_SECONDS = swhc_pkg::WINDOW_DEFAULT,
	parameter int AW             = 9
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	output logic             m_tvalid,
	input  logic             m_tready,
	input  swhc_pkg::sts_t   sts,
	output swhc_pkg::cmd_t   cmd,
	output logic [AW-1:0]    idx
);

	localparam logic [2:0] ST_CLR   = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_MOD   = 3'd2;
	localparam logic [2:0] ST_RD    = 3'd3;
	localparam logic [2:0] ST_WR    = 3'd4;
	localparam logic [2:0] ST_SWEEP = 3'd5;
	localparam logic [2:0] ST_DRAIN = 3'd6;
	localparam logic [2:0] ST_OUT   = 3'd7;

	localparam logic [AW-1:0] IDX_LAST = AW'(WINDOW_SECONDS - 1);
	localparam logic [swhc_pkg::STEP_W-1:0] STEP_LAST =
		swhc_pkg::STEP_W'(swhc_pkg::MOD_STEPS - 1);

	logic [2:0]                   state_q;
	logic [AW-1:0]                idx_q;
	logic [swhc_pkg::STEP_W-1:0]  step_q;
	logic                         m_tvalid_q;
	logic                         out_free;

	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign idx      = idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLR;
			idx_q      <= '0;
			step_q     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_CLR: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q == IDX_LAST) begin
						idx_q   <= '0;
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (s_tvalid) begin
						step_q  <= '0;
						state_q <= ST_MOD;
					end
				end
				ST_MOD: begin
					step_q <= step_q + 1'b1;
					if (step_q == STEP_LAST) begin
						idx_q   <= '0;
						state_q <= sts.hit ? ST_RD : ST_SWEEP;
					end
				end
				ST_RD: begin
					state_q <= ST_WR;
				end
				ST_WR: begin
					state_q <= ST_SWEEP;
				end
				ST_SWEEP: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q == IDX_LAST) begin
						idx_q   <= '0;
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_CLR;
				end
			endcase
		end
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_CLR:   cmd.clr_wr   = 1'b1;
			ST_IDLE:  cmd.mod_init = s_tvalid;
			ST_MOD:   cmd.mod_step = 1'b1;
			ST_RD:    cmd.slot_rd  = 1'b1;
			ST_WR:    cmd.slot_wr  = 1'b1;
			ST_SWEEP: cmd.sweep_rd = 1'b1;
			ST_OUT:   cmd.out_load = out_free;
			default:  cmd = '0;
		endcase
	end

	// output register is never overwritten while a result waits
	a_out_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!m_tvalid_q || m_tready))
		else $error("output loaded while result pending");

	// bucket writes only in the clearing pass or the update step
	a_wr_states: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.clr_wr || cmd.slot_wr) |-> (state_q == ST_CLR || state_q == ST_WR))
		else $error("bucket write outside clear or update");

	// an accepted item always starts the slot computation from step zero
	a_accept_mod: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q == ST_MOD && step_q == '0))
		else $error("accept did not start slot computation");

	// last sweep read is followed by the drain cycle
	a_sweep_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SWEEP && idx_q == IDX_LAST) |=> (state_q == ST_DRAIN))
		else $error("sweep did not end in drain");

endmodule

// ===== sv/swhc_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swhc_dp: datapath of the sliding window hit counter
// Bucket memory, reciprocal timestamp-mod-window unit, bucket update logic,
// saturating window accumulator and output data register.
// ----------------------------------------------------------------------------
module swhc_dp #(
	parameter int WINDOW_SECONDS = swhc_pkg::WINDOW_DEFAULT,
	parameter int AW             = 9
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  swhc_pkg::cmd_t              cmd,
	input  logic [AW-1:0]               idx,
	input  logic [swhc_pkg::TS_W-1:0]   timestamp,
	input  logic                        record_hit,
	output swhc_pkg::sts_t              sts,
	output logic [swhc_pkg::CNT_W-1:0]  window_hits
);

	localparam int RW = AW + 1;  // remainder before the correcting subtract
	localparam int PW = swhc_pkg::TS_W + 32;  // timestamp times reciprocal
	localparam logic [RW-1:0] WIN_R = RW'(WINDOW_SECONDS);
	localparam logic [swhc_pkg::CNT_W-1:0] WIN_C = swhc_pkg::CNT_W'(WINDOW_SECONDS);
	localparam logic [swhc_pkg::CNT_W-1:0] CNT_MAX = '1;
	// floor(2^32 / window), clamped to 32 bits; quotient estimate is low by
	// at most one, so one compare and subtract finishes the remainder
	localparam longint unsigned RECIP_FULL = (64'd1 << 32) / 64'(WINDOW_SECONDS);
	localparam logic [31:0] RECIP =
		(RECIP_FULL > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(RECIP_FULL);

	typedef struct packed {
		logic [swhc_pkg::TS_W-1:0]  stamp;
		logic [swhc_pkg::CNT_W-1:0] count;
	} entry_t;

	entry_t                       mem [WINDOW_SECONDS];
	entry_t                       rd_q;
	entry_t                       upd;
	entry_t                       wdata;
	logic [AW-1:0]                rd_addr;
	logic [AW-1:0]                wr_addr;
	logic                         rd_en;
	logic                         wr_en;

	logic [swhc_pkg::TS_W-1:0]    ts_q;
	logic                         hit_q;
	logic [PW-1:0]                prod;
	logic [RW-1:0]                q_s1;
	logic [RW-1:0]                qw;
	logic [RW-1:0]                rem_est;
	logic [RW-1:0]                rem_q;
	logic [AW-1:0]                slot;
	logic                         acc_s1;
	logic [swhc_pkg::CNT_W-1:0]   sum_q;
	logic [swhc_pkg::CNT_W-1:0]   out_q;
	logic [swhc_pkg::CNT_W-1:0]   limit;
	logic                         in_win;
	logic [swhc_pkg::CNT_W:0]     sum_ext;

	// step 1: quotient estimate; step 2: remainder in RW bits, then correct.
	// Only the low RW bits matter since the true remainder is below 2^RW.
	assign prod    = PW'(ts_q) * PW'(RECIP);
	assign qw      = q_s1 * WIN_R;
	assign rem_est = ts_q[RW-1:0] - qw;
	assign slot    = rem_q[AW-1:0];

	assign rd_en   = cmd.slot_rd || cmd.sweep_rd;
	assign rd_addr = cmd.slot_rd ? slot : idx;
	assign wr_en   = cmd.clr_wr || (cmd.slot_wr && hit_q);
	assign wr_addr = cmd.clr_wr ? idx : slot;

	always_comb begin
		upd.stamp = ts_q;
		if (rd_q.stamp != ts_q) begin
			upd.count = swhc_pkg::CNT_W'(1);
		end else if (rd_q.count == CNT_MAX) begin
			upd.count = CNT_MAX;
		end else begin
			upd.count = rd_q.count + 1'b1;
		end
		wdata = cmd.clr_wr ? '0 : upd;
	end

	// stamp + window without wrap; stamp is 31 bits so 32 suffice
	assign limit   = {1'b0, rd_q.stamp} + WIN_C;
	assign in_win  = ({1'b0, ts_q} < limit);
	assign sum_ext = {1'b0, sum_q} + {1'b0, rd_q.count};

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wdata;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_s1 <= 1'b0;
		end else begin
			acc_s1 <= cmd.sweep_rd;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mod_init) begin
			ts_q  <= timestamp;
			hit_q <= record_hit;
			rem_q <= '0;
			sum_q <= '0;
		end else begin
			if (cmd.mod_step) begin
				q_s1  <= prod[32 +: RW];
				rem_q <= (rem_est >= WIN_R) ? (rem_est - WIN_R) : rem_est;
			end
			if (acc_s1 && in_win) begin
				sum_q <= sum_ext[swhc_pkg::CNT_W] ? CNT_MAX
					: sum_ext[swhc_pkg::CNT_W-1:0];
			end
		end
		if (cmd.out_load) begin
			out_q <= sum_q;
		end
	end

	assign sts.hit     = hit_q;
	assign window_hits = out_q;

endmodule

// ===== sv/sliding_window_hit_counter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_hit_counter: hits seen in the last WINDOW_SECONDS seconds
// Bucket per second slot with stamp and saturating count, summed per item.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_*: s_tdata carries the timestamp in seconds (must not
//   decrease across items), s_tuser set records one hit at that time.
//   Output stream m_*: one transfer per input item with the saturating
//   number of hits whose bucket stamp is less than WINDOW_SECONDS before
//   the item's timestamp.
//   One item is processed at a time. An item finds its slot by a
//   reciprocal multiply, then a remainder with one correcting subtract,
//   updates the bucket on a hit, then sweeps the bucket memory through
//   its single read port, followed by drain and output load.
//   The bucket sweep over the memory port sets the time per item.
//   After reset a clearing pass zeroes every bucket; s_tready stays low
//   until it ends.
//   The result sits in an output register. The next item is accepted while
//   it waits; if m_tready is still low when that item's sum is ready, the
//   block holds it until the pending result is taken.
// ----------------------------------------------------------------------------
module sliding_window_hit_counter #(
	parameter int WINDOW_SECONDS = swhc_pkg::WINDOW_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	// input items
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [30:0] timestamp, [31] zero pad
	input  logic        s_tuser,   // [0] record_hit
	// results
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata    // [31:0] window_hits
);

	// bucket address width, at least one bit
	localparam int AW = (WINDOW_SECONDS > 1) ? $clog2(WINDOW_SECONDS) : 1;

	swhc_pkg::cmd_t  cmd;
	swhc_pkg::sts_t  sts;
	logic [AW-1:0]   idx;

	// sequencer: clearing pass, slot steps, update, sweep, output handshake
	swhc_ctrl #(
		.WINDOW_SECONDS (WINDOW_SECONDS),
		.AW             (AW)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd),
		.idx      (idx)
	);

	// bucket memory, mod unit, accumulator and output data
	swhc_dp #(
		.WINDOW_SECONDS (WINDOW_SECONDS),
		.AW             (AW)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.idx         (idx),
		.timestamp   (s_tdata[swhc_pkg::TS_W-1:0]),
		.record_hit  (s_tuser),
		.sts         (sts),
		.window_hits (m_tdata)
	);

endmodule
